// ===== src/baudot_fsk_transmitter_core_macros.svh =====
// Assertion macros shared by the transmitter modules.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef BAUDOT_FSK_TRANSMITTER_CORE_MACROS_SVH
`define BAUDOT_FSK_TRANSMITTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/bft_pkg.sv =====
// Shared types and constants for the Baudot FSK transmitter.
// Used by every module of the block; depends on nothing else.
package bft_pkg;

	// Command codes.
	localparam logic [1:0] CMD_PUSH    = 2'd0;
	localparam logic [1:0] CMD_TICK    = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_BITS_PER_CHAR = 2'd0;
	localparam logic [1:0] REG_DIDDLE_MODE   = 2'd1;
	localparam logic [1:0] REG_INVERT_OUTPUT = 2'd2;

	// Baudot shift and fill codes.
	localparam logic [7:0] CODE_LTR   = 8'h1f;
	localparam logic [7:0] CODE_FIGS  = 8'h1b;
	localparam logic [7:0] CODE_BLANK = 8'h00;

	localparam logic [3:0] BITS_PER_CHAR_RST = 4'd5;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] char_code;
	} bft_cmd_t;

	typedef struct packed {
		logic       line_mark;
		logic       break_drive;
		logic       line_changed;
		logic       idle;
		logic [8:0] queue_count;
		logic       push_dropped;
	} bft_res_t;

	// Requests from the command decode and the serialiser to the character queue.
	typedef struct packed {
		logic       push;
		logic       pop;
		logic       clear;
		logic [7:0] wdata;
	} bft_fifo_ctl_t;

	// Queue status seen by the serialiser and the result assembly.
	typedef struct packed {
		logic       empty;
		logic       full;
		logic [7:0] head;
	} bft_fifo_stat_t;

	// Line status after the current transaction.
	typedef struct packed {
		logic line_mark;
		logic line_changed;
		logic idle;
	} bft_line_stat_t;

endpackage

// ===== src/baudot_fsk_transmitter_core.sv =====
// Baudot FSK transmitter top level: command register, configuration, queue, serialiser, results.
// Depends on bft_pkg, bft_fifo, bft_ser and bft_obuf.
//
// Each command transaction (push, tick, restart or the unused code) yields exactly one result transaction.
// The block takes one command per clock cycle while cmd_stall is low. A command waits in the
// command register until the result side has room, and its result is then loaded into the
// result register, from which the receiver takes it. A stalled result fills the skid stage;
// commands are then held off until the receiver takes results again. The character queue is a
// memory of FIFO_DEPTH entries with a registered read, whose head entry is prefetched so a tick
// can use it at once. A restart empties the queue by resetting its pointers, so no clearing pass
// is needed after reset or restart. Configuration writes take effect on the next command.
module baudot_fsk_transmitter_core import bft_pkg::*; #(
	parameter int FIFO_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  bft_cmd_t   cmd,
	output logic       res_valid,
	input  logic       res_stall,
	output bft_res_t   res,
	input  logic       cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data
);

	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	logic             cmd_valid_s1;
	bft_cmd_t         cmd_s1;
	logic             fire;
	logic             obuf_full;
	logic [3:0]       bits_per_char_q;
	logic             diddle_mode_q;
	logic             invert_output_q;
	bft_fifo_ctl_t    fifo_ctl;
	bft_fifo_stat_t   fifo_stat;
	logic [CNT_W-1:0] count_n;
	logic [CNT_W+8:0] count_ext;
	logic             pop;
	logic             is_tick;
	logic             is_restart;
	bft_line_stat_t   line_stat;
	bft_res_t         result;

	// Command register: a transaction is processed when the result side has room.
	assign fire      = cmd_valid_s1 && !obuf_full;
	assign cmd_stall = cmd_valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (cmd_valid && !cmd_stall) begin
			cmd_valid_s1 <= 1'b1;
		end else if (fire) begin
			cmd_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_per_char_q <= BITS_PER_CHAR_RST;
			diddle_mode_q   <= 1'b1;
			invert_output_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_BITS_PER_CHAR: bits_per_char_q <= cfg_data;
				REG_DIDDLE_MODE:   diddle_mode_q   <= cfg_data[0];
				REG_INVERT_OUTPUT: invert_output_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Command decode.
	assign is_tick    = fire && (cmd_s1.command == CMD_TICK);
	assign is_restart = fire && (cmd_s1.command == CMD_RESTART);

	assign fifo_ctl.push  = fire && (cmd_s1.command == CMD_PUSH);
	assign fifo_ctl.pop   = pop;
	assign fifo_ctl.clear = is_restart;
	assign fifo_ctl.wdata = cmd_s1.char_code;

	bft_fifo #(
		.DEPTH (FIFO_DEPTH),
		.CNT_W (CNT_W)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (fifo_ctl),
		.stat    (fifo_stat),
		.count_n (count_n)
	);

	bft_ser u_ser (
		.clk           (clk),
		.arst_n        (arst_n),
		.tick          (is_tick),
		.restart       (is_restart),
		.bits_per_char (bits_per_char_q),
		.diddle_mode   (diddle_mode_q),
		.fifo_stat     (fifo_stat),
		.pop           (pop),
		.line_stat     (line_stat)
	);

	// Result assembly; the queue count is reported in its nine-bit field.
	assign count_ext = {9'd0, count_n};

	always_comb begin
		result.line_mark    = line_stat.line_mark;
		result.break_drive  = invert_output_q ? line_stat.line_mark : !line_stat.line_mark;
		result.line_changed = line_stat.line_changed;
		result.idle         = line_stat.idle;
		result.queue_count  = count_ext[8:0];
		result.push_dropped = fifo_ctl.push && fifo_stat.full;
	end

	bft_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.data      (result),
		.full      (obuf_full),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// ===== src/bft_fifo.sv =====
// Character queue: a single-port-write, registered-read memory with a head forward path.
// Depends on bft_pkg and on the shared assertion macros.
`include "baudot_fsk_transmitter_core_macros.svh"

module bft_fifo import bft_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bft_fifo_ctl_t    ctl,
	output bft_fifo_stat_t   stat,
	output logic [CNT_W-1:0] count_n
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [7:0]       mem [DEPTH];
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       rd_data_q;
	logic [7:0]       fwd_data_q;
	logic             fwd_q;
	logic             wr_en;
	logic [PTR_W-1:0] rd_ptr_n;
	logic [PTR_W-1:0] wr_ptr_n;

	// Status of the queue before the current transaction.
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_FULL);
	assign stat.head  = fwd_q ? fwd_data_q : rd_data_q;

	assign wr_en = ctl.push && !stat.full;

	// Pointer and occupancy updates; the pointers wrap at any depth.
	always_comb begin
		rd_ptr_n = rd_ptr_q;
		wr_ptr_n = wr_ptr_q;
		count_n  = count_q;
		if (ctl.clear) begin
			rd_ptr_n = '0;
			wr_ptr_n = '0;
			count_n  = '0;
		end else if (wr_en) begin
			wr_ptr_n = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			count_n  = count_q + 1'b1;
		end else if (ctl.pop) begin
			rd_ptr_n = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			count_n  = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
			fwd_q    <= 1'b0;
		end else begin
			rd_ptr_q <= rd_ptr_n;
			wr_ptr_q <= wr_ptr_n;
			count_q  <= count_n;
			// A write to the entry that becomes the head is not yet visible in the read data.
			fwd_q    <= wr_en && (wr_ptr_q == rd_ptr_n);
		end
	end

	// Memory: one write port, one registered read of the next head entry.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= ctl.wdata;
		end
		rd_data_q  <= mem[rd_ptr_n];
		fwd_data_q <= ctl.wdata;
	end

	`BFT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_FULL, "queue occupancy beyond depth")
	`BFT_ASSERT_NOW(a_pop_nonempty, ctl.pop, !stat.empty, "character taken from empty queue")
	`BFT_ASSERT_NEXT(a_clear_empty, ctl.clear, (count_q == '0) && (rd_ptr_q == wr_ptr_q),
		"queue not empty after restart")

endmodule

// ===== src/bft_ser.sv =====
// Staging register, shift tracking and frame serialiser of the transmitter.
// Depends on bft_pkg for codes and status types.
module bft_ser import bft_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           tick,
	input  logic           restart,
	input  logic [3:0]     bits_per_char,
	input  logic           diddle_mode,
	input  bft_fifo_stat_t fifo_stat,
	output logic           pop,
	output bft_line_stat_t line_stat
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DATA,
		PH_STOP
	} phase_t;

	phase_t     phase_q, phase_n;
	logic [7:0] staged_char_q, staged_char_n;
	logic       staged_valid_q, staged_valid_n;
	logic [7:0] shift_q, shift_n;
	logic [3:0] bits_left_q, bits_left_n;
	logic [1:0] hold_q, hold_n;
	logic       line_q, line_n;
	logic       drv_level_q, drv_level_n;
	logic       drv_known_q, drv_known_n;
	logic       idle_q, idle_n;
	logic       figs_mode_q, figs_mode_n;
	logic       figs_pend_q, figs_pend_n;
	logic       changed;

	// A restart resets all state; a tick refills the staging register, then runs one serialiser tick.
	always_comb begin
		phase_n        = phase_q;
		staged_char_n  = staged_char_q;
		staged_valid_n = staged_valid_q;
		shift_n        = shift_q;
		bits_left_n    = bits_left_q;
		hold_n         = hold_q;
		line_n         = line_q;
		drv_level_n    = drv_level_q;
		drv_known_n    = drv_known_q;
		idle_n         = idle_q;
		figs_mode_n    = figs_mode_q;
		figs_pend_n    = figs_pend_q;
		pop            = 1'b0;
		changed        = 1'b0;
		if (restart) begin
			phase_n        = PH_IDLE;
			staged_char_n  = '0;
			staged_valid_n = 1'b0;
			shift_n        = '0;
			bits_left_n    = '0;
			hold_n         = '0;
			line_n         = 1'b1;
			drv_level_n    = 1'b0;
			drv_known_n    = 1'b0;
			idle_n         = 1'b0;
			figs_mode_n    = 1'b0;
			figs_pend_n    = 1'b0;
		end else if (tick) begin
			// Fill an empty staging register: idle fill, pending FIGS, then the queue.
			if (!staged_valid_q) begin
				staged_valid_n = 1'b1;
				if (fifo_stat.empty) begin
					if (diddle_mode) begin
						staged_char_n = CODE_LTR;
						if (figs_mode_q) begin
							figs_pend_n = 1'b1;
						end
					end else begin
						staged_char_n = CODE_BLANK;
					end
				end else if (figs_pend_q) begin
					staged_char_n = CODE_FIGS;
					figs_pend_n   = 1'b0;
				end else begin
					staged_char_n = fifo_stat.head;
					pop           = 1'b1;
					if (fifo_stat.head == CODE_LTR) begin
						figs_mode_n = 1'b0;
					end else if (fifo_stat.head == CODE_FIGS) begin
						figs_mode_n = 1'b1;
					end
				end
			end

			// Serialiser: hold the current level, or step through the frame.
			if (hold_q != 2'd0) begin
				hold_n = hold_q - 2'd1;
			end else begin
				unique case (phase_q)
					PH_DATA: begin
						line_n      = shift_q[0];
						shift_n     = {1'b0, shift_q[7:1]};
						bits_left_n = bits_left_q - 4'd1;
						if (bits_left_n == 4'd0) begin
							phase_n = PH_STOP;
						end
						hold_n = 2'd1;
					end
					PH_STOP: begin
						line_n  = 1'b1;
						hold_n  = 2'd2;
						phase_n = PH_IDLE;
					end
					default: begin
						if (staged_valid_n) begin
							shift_n        = staged_char_n;
							staged_valid_n = 1'b0;
							bits_left_n    = bits_per_char;
							line_n         = 1'b0;
							phase_n        = PH_DATA;
							hold_n         = 2'd1;
							idle_n         = 1'b0;
						end else begin
							phase_n = PH_IDLE;
							line_n  = 1'b1;
							idle_n  = 1'b1;
						end
					end
				endcase
			end

			// The physical line is rewritten on the first tick and on every level change.
			if (!drv_known_q || (drv_level_q != line_n)) begin
				drv_level_n = line_n;
				drv_known_n = 1'b1;
				changed     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			staged_char_q  <= '0;
			staged_valid_q <= 1'b0;
			shift_q        <= '0;
			bits_left_q    <= '0;
			hold_q         <= '0;
			line_q         <= 1'b1;
			drv_level_q    <= 1'b0;
			drv_known_q    <= 1'b0;
			idle_q         <= 1'b0;
			figs_mode_q    <= 1'b0;
			figs_pend_q    <= 1'b0;
		end else begin
			phase_q        <= phase_n;
			staged_char_q  <= staged_char_n;
			staged_valid_q <= staged_valid_n;
			shift_q        <= shift_n;
			bits_left_q    <= bits_left_n;
			hold_q         <= hold_n;
			line_q         <= line_n;
			drv_level_q    <= drv_level_n;
			drv_known_q    <= drv_known_n;
			idle_q         <= idle_n;
			figs_mode_q    <= figs_mode_n;
			figs_pend_q    <= figs_pend_n;
		end
	end

	assign line_stat.line_mark    = line_n;
	assign line_stat.line_changed = changed;
	assign line_stat.idle         = idle_n;

endmodule

// ===== src/bft_obuf.sv =====
// Result register with a skid stage, so a waiting result does not block new work.
// Depends on bft_pkg for the result type.
module bft_obuf import bft_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  bft_res_t data,
	output logic     full,
	output logic     res_valid,
	input  logic     res_stall,
	output bft_res_t res
);

	logic     out_valid_q;
	logic     skid_valid_q;
	bft_res_t out_q;
	bft_res_t skid_q;
	logic     take;

	assign take = out_valid_q && !res_stall;

	// Control: the skid stage fills only when the result register is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (load) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (load) begin
			if (out_valid_q && !take) begin
				skid_q <= data;
			end else begin
				out_q <= data;
			end
		end
	end

	assign full      = skid_valid_q;
	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

// ===== dv/tb_baudot_fsk_transmitter_core.sv =====
// Self-checking testbench for the Baudot FSK transmitter core.
// Depends on bft_pkg and baudot_fsk_transmitter_core; holds its own line and queue predictor.
module tb_baudot_fsk_transmitter_core import bft_pkg::*; ();

	localparam int QUEUE_DEPTH = 256;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 60;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Serialiser phases of the predictor.
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_DATA = 2'd1;
	localparam logic [1:0] PH_STOP = 2'd2;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	bft_cmd_t   cmd = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	bft_res_t   res;
	logic       cfg_write = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [3:0] cfg_data = '0;

	baudot_fsk_transmitter_core #(.FIFO_DEPTH(QUEUE_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Predictor state: configuration, character queue, staging and serialiser.
	logic [3:0] bits_cfg;
	logic       diddle_on;
	logic       invert_on;
	logic [7:0] q_mem [QUEUE_DEPTH];
	logic [7:0] q_rd;
	logic [7:0] q_wr;
	logic [8:0] q_fill;
	logic [7:0] stage_code;
	logic       stage_full;
	logic [7:0] shreg;
	logic [3:0] bits_left;
	logic [1:0] phase;
	logic [1:0] hold;
	logic       level;
	logic       drv_level;
	logic       drv_known;
	logic       idle_now;
	logic       figs_mode;
	logic       figs_pend;

	bft_res_t line_status_due [$];
	int       mismatches = 0;
	bit       quiet = 1'b0;
	int       hold_requests = 0;
	int       hold_served = 0;
	int       hold_left = 0;
	int       stuck_cycles = 0;

	function automatic void clear_link_state();
		q_rd = '0;
		q_wr = '0;
		q_fill = '0;
		stage_code = '0;
		stage_full = 1'b0;
		shreg = '0;
		bits_left = '0;
		phase = PH_IDLE;
		hold = '0;
		level = 1'b1;
		drv_level = 1'b0;
		drv_known = 1'b0;
		idle_now = 1'b0;
		figs_mode = 1'b0;
		figs_pend = 1'b0;
	endfunction

	// Picks the next code to stage: idle fill, a pending figures shift, or the queue head.
	function automatic logic [7:0] fetch_code();
		logic [7:0] c;
		if (q_fill == 0) begin
			if (diddle_on) begin
				c = CODE_LTR;
				if (figs_mode)
					figs_pend = 1'b1;
			end else begin
				c = CODE_BLANK;
			end
		end else if (figs_pend) begin
			c = CODE_FIGS;
			figs_pend = 1'b0;
		end else begin
			c = q_mem[q_rd];
			q_rd = q_rd + 8'd1;
			q_fill = q_fill - 9'd1;
			if (c == CODE_LTR)
				figs_mode = 1'b0;
			else if (c == CODE_FIGS)
				figs_mode = 1'b1;
		end
		return c;
	endfunction

	// One tick of the serialiser: start bit, data bits LSB first, stop bit.
	function automatic void advance_line();
		if (hold != 0) begin
			hold = hold - 2'd1;
		end else if (phase == PH_DATA) begin
			level = shreg[0];
			shreg = shreg >> 1;
			bits_left = bits_left - 4'd1;
			if (bits_left == 0)
				phase = PH_STOP;
			hold = 2'd1;
		end else if (phase == PH_STOP) begin
			level = 1'b1;
			hold = 2'd2;
			phase = PH_IDLE;
		end else if (stage_full) begin
			shreg = stage_code;
			stage_full = 1'b0;
			bits_left = bits_cfg;
			level = 1'b0;
			phase = PH_DATA;
			hold = 2'd1;
			idle_now = 1'b0;
		end else begin
			phase = PH_IDLE;
			level = 1'b1;
			idle_now = 1'b1;
		end
	endfunction

	function automatic bft_res_t transmit_step(input bft_cmd_t c);
		bft_res_t r;
		logic     changed;
		logic     dropped;
		changed = 1'b0;
		dropped = 1'b0;
		case (c.command)
			CMD_PUSH: begin
				if (q_fill < QUEUE_DEPTH) begin
					q_mem[q_wr] = c.char_code;
					q_wr = q_wr + 8'd1;
					q_fill = q_fill + 9'd1;
				end else begin
					dropped = 1'b1;
				end
			end
			CMD_TICK: begin
				if (!stage_full) begin
					stage_code = fetch_code();
					stage_full = 1'b1;
				end
				advance_line();
				if (!drv_known || drv_level != level) begin
					drv_level = level;
					drv_known = 1'b1;
					changed = 1'b1;
				end
			end
			CMD_RESTART: clear_link_state();
			default: ;
		endcase
		r.line_mark = level;
		r.break_drive = invert_on ? level : ~level;
		r.line_changed = changed;
		r.idle = idle_now;
		r.queue_count = q_fill;
		r.push_dropped = dropped;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(input string what, input int got, input int want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	// Result checker: each accepted transaction against the oldest prediction.
	always @(posedge clk) begin
		bft_res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (line_status_due.size() == 0) begin
				report_mismatch("result without a pending command", 1, 0);
			end else begin
				want = line_status_due.pop_front();
				check_field("line_mark", res.line_mark, want.line_mark);
				check_field("break_drive", res.break_drive, want.break_drive);
				check_field("line_changed", res.line_changed, want.line_changed);
				check_field("idle", res.idle, want.idle);
				check_field("queue_count", res.queue_count, want.queue_count);
				check_field("push_dropped", res.push_dropped, want.push_dropped);
			end
		end
	end

	// Result receiver: random stalls, plus long hold-offs on request.
	always @(negedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (quiet) begin
			res_stall <= 1'b0;
		end else begin
			res_stall <= ($urandom_range(0, 99) < 10);
		end
	end

	// Watchdog on cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("** baudot_fsk_transmitter_core: FAILED **");
			$finish;
		end
	end

	// Offers one command; called and returns at a falling edge.
	task automatic send_cmd(input logic [1:0] op, input logic [7:0] code);
		bft_cmd_t c;
		c.command = op;
		c.char_code = code;
		if (!quiet && $urandom_range(0, 99) < 10) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (cmd_stall);
		line_status_due.push_back(transmit_step(c));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		while (line_status_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [3:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_BITS_PER_CHAR: bits_cfg = value;
			REG_DIDDLE_MODE:   diddle_on = value[0];
			REG_INVERT_OUTPUT: invert_on = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Registers change only once the pipeline has emptied.
	task automatic configure(input logic [3:0] bits, input logic diddle, input logic inv);
		wait_drained();
		repeat (4) @(negedge clk);
		write_reg(REG_BITS_PER_CHAR, bits);
		write_reg(REG_DIDDLE_MODE, {3'b000, diddle});
		write_reg(REG_INVERT_OUTPUT, {3'b000, inv});
	endtask

	function automatic logic [7:0] random_code();
		int k;
		k = $urandom_range(0, 9);
		if (k < 2)
			return CODE_LTR;
		if (k < 4)
			return CODE_FIGS;
		return 8'($urandom_range(0, 255));
	endfunction

	// Mostly ticks and pushes, so frames and shift changes run through.
	task automatic send_random(input int count);
		int r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 62)
				send_cmd(CMD_TICK, 8'($urandom_range(0, 255)));
			else if (r < 94)
				send_cmd(CMD_PUSH, random_code());
			else if (r < 97)
				send_cmd(CMD_RESTART, 8'($urandom_range(0, 255)));
			else
				send_cmd(CMD_UNUSED, 8'($urandom_range(0, 255)));
		end
	endtask

	// Reset defaults: field extremes, shift codes, restart and the unused command.
	task automatic test_directed();
		send_cmd(CMD_TICK, 8'h00);
		send_cmd(CMD_PUSH, 8'hff);
		send_cmd(CMD_PUSH, CODE_FIGS);
		send_cmd(CMD_PUSH, 8'h00);
		send_cmd(CMD_PUSH, CODE_LTR);
		send_cmd(CMD_UNUSED, 8'hff);
		repeat (12) send_cmd(CMD_TICK, 8'hff);
		send_cmd(CMD_RESTART, 8'h00);
		send_cmd(CMD_TICK, 8'h00);
		send_cmd(CMD_TICK, 8'h00);
	endtask

	// Fixed register settings, the extremes among them; no restart between phases.
	task automatic test_register_settings();
		logic [3:0] bits_tab [6] = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd9, 4'd5};
		logic       didl_tab [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		logic       inv_tab  [6] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
		for (int i = 0; i < 6; i++) begin
			configure(bits_tab[i], didl_tab[i], inv_tab[i]);
			send_random(100);
		end
	endtask

	// Fill the queue past its depth, starting with a long receiver hold-off.
	task automatic test_queue_overflow();
		configure(4'd5, 1'b1, 1'b0);
		send_cmd(CMD_RESTART, 8'h00);
		quiet = 1'b1;
		hold_requests++;
		repeat (QUEUE_DEPTH + 4) send_cmd(CMD_PUSH, random_code());
		quiet = 1'b0;
		repeat (6) send_cmd(CMD_TICK, 8'h00);
		send_cmd(CMD_RESTART, 8'h00);
	endtask

	// Random settings per phase, one phase without any idling.
	task automatic test_random_traffic();
		logic [3:0] bits;
		for (int p = 0; p < 3; p++) begin
			if ($urandom_range(0, 3) == 0)
				bits = 4'($urandom_range(0, 15));
			else
				bits = 4'($urandom_range(1, 6));
			configure(bits, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			quiet = (p == 1);
			send_random(110);
		end
		quiet = 1'b0;
	endtask

	initial begin
		bits_cfg = BITS_PER_CHAR_RST;
		diddle_on = 1'b1;
		invert_on = 1'b0;
		clear_link_state();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_register_settings();
		test_queue_overflow();
		test_random_traffic();
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("** baudot_fsk_transmitter_core: PASSED **");
		else
			$display("** baudot_fsk_transmitter_core: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/bft_pkg.sv
src/bft_fifo.sv
src/bft_ser.sv
src/bft_obuf.sv
src/baudot_fsk_transmitter_core.sv
dv/tb_baudot_fsk_transmitter_core.sv
